@@ rtl/multi_reader_sample_ring_assert.svh @@
// Assertion macros used by the sample ring back end (rsr_back).
// Each macro expects the signals clk and rst to be visible where it is used.
`ifndef MULTI_READER_SAMPLE_RING_ASSERT_SVH
`define MULTI_READER_SAMPLE_RING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRSR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be true.
`define MRSR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ rtl/rsr_pkg.sv @@
// Shared types, codes and constants of the multi-reader sample ring.
// Used by every module of the block except rsr_fifo; depends on nothing else.
package rsr_pkg;

  // Default values of the top-level parameters.
  localparam int RING_DEPTH_DEF   = 16384;
  localparam int READER_SLOTS_DEF = 4;
  localparam int MAX_READ_DEF     = 64;

  // Fixed field widths of the request and result items.
  localparam int FUNC_W      = 2;
  localparam int SAMPLE_W    = 16;
  localparam int HANDLE_W    = 4;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 3;
  localparam int RING_SIZE_W = 15;
  localparam int TOTAL_W     = 64;
  localparam int SLOT_W      = 3;

  // Depths of the request and result queues.
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_WRITE      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd4;

  // Classified command kinds passed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_REGISTER,
    CMD_UNREGISTER,
    CMD_READ,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [SLOT_W-1:0]           slot;
    logic [COUNT_W-1:0]          count;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [HANDLE_W-1:0]         handle;
    logic                        last;
    logic                        overrun;
  } result_t;

endpackage

@@ rtl/rsr_fifo.sv @@
// Small register-based queue used for requests and for results.
// Standalone; holds WIDTH-bit words, DEPTH entries deep.
module rsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rd_data,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign count   = fill;
  assign rd_data = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/rsr_front.sv @@
// Front end of the sample ring: checks and classifies each incoming request.
// Depends on rsr_pkg for field widths, function codes and the command type.
module rsr_front #(
  parameter int READER_SLOTS = rsr_pkg::READER_SLOTS_DEF,
  parameter int MAX_READ     = rsr_pkg::MAX_READ_DEF
) (
  input  logic [rsr_pkg::FUNC_W-1:0]          func,
  input  logic signed [rsr_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [rsr_pkg::HANDLE_W-1:0]        reader_handle,
  input  logic [rsr_pkg::COUNT_W-1:0]         read_count,
  output rsr_pkg::cmd_t                       cmd
);

  logic handle_bad;
  logic count_big;

  // A handle is usable only if it names an existing slot.
  assign handle_bad = (reader_handle == '0) ||
                      (reader_handle > rsr_pkg::HANDLE_W'(READER_SLOTS));
  assign count_big  = (read_count > rsr_pkg::COUNT_W'(MAX_READ));

  // Classification into one command for the back end.
  always_comb begin
    cmd.sample = sample_in;
    cmd.slot   = rsr_pkg::SLOT_W'(reader_handle - rsr_pkg::HANDLE_W'(1));
    cmd.count  = count_big ? rsr_pkg::COUNT_W'(MAX_READ) : read_count;
    unique case (func)
      rsr_pkg::FUNC_WRITE:      cmd.kind = rsr_pkg::CMD_WRITE;
      rsr_pkg::FUNC_REGISTER:   cmd.kind = rsr_pkg::CMD_REGISTER;
      rsr_pkg::FUNC_UNREGISTER: cmd.kind = handle_bad ? rsr_pkg::CMD_BAD
                                                       : rsr_pkg::CMD_UNREGISTER;
      rsr_pkg::FUNC_READ: begin
        if (handle_bad || read_count == '0) begin
          cmd.kind = rsr_pkg::CMD_BAD;
        end else begin
          cmd.kind = rsr_pkg::CMD_READ;
        end
      end
      default:                  cmd.kind = rsr_pkg::CMD_BAD;
    endcase
  end

endmodule

@@ rtl/rsr_back.sv @@
// Back end of the sample ring: sample memory, writer and reader state, read sequencer.
// Depends on rsr_pkg and on the assertion macros in multi_reader_sample_ring_assert.svh.
`include "multi_reader_sample_ring_assert.svh"

module rsr_back #(
  parameter int RING_DEPTH   = rsr_pkg::RING_DEPTH_DEF,
  parameter int READER_SLOTS = rsr_pkg::READER_SLOTS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_write,
  input  logic [rsr_pkg::RING_SIZE_W-1:0]             cfg_data,
  input  rsr_pkg::cmd_t                               cmd,
  input  logic                                        cmd_empty,
  output logic                                        cmd_pop,
  input  logic [$clog2(rsr_pkg::RES_DEPTH+1)-1:0]     res_count,
  output logic                                        res_push,
  output rsr_pkg::result_t                            res_data
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int PW  = AW + 1;
  localparam int SW  = (PW > rsr_pkg::RING_SIZE_W) ? PW : rsr_pkg::RING_SIZE_W;
  localparam int IW  = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int OCW = $clog2(rsr_pkg::RES_DEPTH + 1);
  localparam int TW  = rsr_pkg::TOTAL_W;
  localparam int NW  = rsr_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIFF   = 4'b0010,
    S_CHECK  = 4'b0100,
    S_STREAM = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Sample memory.
  logic [rsr_pkg::SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [rsr_pkg::SAMPLE_W-1:0] mem_q;
  logic                         mem_we;
  logic                         mem_re;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;

  // Writer and reader state.
  logic [TW-1:0]                 write_total;
  logic [AW-1:0]                 write_slot;
  logic [READER_SLOTS-1:0]       reader_active;
  logic [TW-1:0]                 reader_total [READER_SLOTS];
  logic [AW-1:0]                 reader_slot  [READER_SLOTS];
  logic [rsr_pkg::RING_SIZE_W-1:0] ring_size;
  logic                          size_default;

  // Read sequencer working registers.
  logic [IW-1:0]   cur;
  logic [NW-1:0]   req_count;
  logic [TW-1:0]   avail;
  logic [NW-1:0]   remaining;
  logic            ovr;

  // Result staging register in front of the result queue.
  logic              pend_valid;
  logic              pend_mem;
  rsr_pkg::result_t  pend;

  // Decisions of the current cycle.
  logic              issue;
  logic              issue_mem;
  rsr_pkg::result_t  pend_in;
  logic              room;
  logic [IW-1:0]     ci;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic [PW-1:0]     used_size;
  logic [SW-1:0]     rs_ext;
  logic [TW-1:0]     size_wide;
  logic [NW-1:0]     avail_sat;
  logic [NW-1:0]     size_sat;
  logic [NW-1:0]     n_small;
  logic [NW-1:0]     n_count;

  // A stored position at or past the memory depth is taken as zero.
  function automatic logic [AW-1:0] guard(input logic [AW-1:0] pos);
    return ({1'b0, pos} >= PW'(RING_DEPTH)) ? '0 : pos;
  endfunction

  // Next position, wrapping at the ring size in use.
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                            input logic [PW-1:0] size);
    logic [PW-1:0] nxt;
    nxt = PW'(pos) + PW'(1);
    return (nxt >= size) ? '0 : nxt[AW-1:0];
  endfunction

  // Ring size in use: zero acts as one, oversize values act as the full depth.
  assign rs_ext = SW'(ring_size);
  always_comb begin
    if (size_default) begin
      used_size = PW'(RING_DEPTH);
    end else if (rs_ext == '0) begin
      used_size = PW'(1);
    end else if (rs_ext > SW'(RING_DEPTH)) begin
      used_size = PW'(RING_DEPTH);
    end else begin
      used_size = PW'(rs_ext);
    end
  end
  assign size_wide = TW'(used_size);

  // Room in the result queue, counting the staged result.
  assign room = ((OCW + 1)'(res_count) + (OCW + 1)'(pend_valid)) <
                (OCW + 1)'(rsr_pkg::RES_DEPTH);

  assign ci = cmd.slot[IW-1:0];

  // Lowest inactive reader slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = READER_SLOTS - 1; i >= 0; i--) begin
      if (!reader_active[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Samples to deliver: the least of available, ring size and requested count.
  assign avail_sat = (|avail[TW-1:NW]) ? '1 : avail[NW-1:0];
  assign size_sat  = (|size_wide[TW-1:NW]) ? '1 : size_wide[NW-1:0];
  assign n_small   = (avail_sat < size_sat) ? avail_sat : size_sat;
  assign n_count   = (n_small < req_count) ? n_small : req_count;

  // Sequencer control.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    issue      = 1'b0;
    issue_mem  = 1'b0;
    mem_we     = 1'b0;
    pend_in    = '0;
    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.kind)
            rsr_pkg::CMD_WRITE: begin
              cmd_pop = 1'b1;
              mem_we  = 1'b1;
            end
            rsr_pkg::CMD_REGISTER: begin
              if (room) begin
                cmd_pop      = 1'b1;
                issue        = 1'b1;
                pend_in.last = 1'b1;
                if (free_found) begin
                  pend_in.status = rsr_pkg::STATUS_OK;
                  pend_in.handle = rsr_pkg::HANDLE_W'(free_idx) + rsr_pkg::HANDLE_W'(1);
                end else begin
                  pend_in.status = rsr_pkg::STATUS_NO_SLOT;
                end
              end
            end
            rsr_pkg::CMD_UNREGISTER: begin
              if (room) begin
                cmd_pop        = 1'b1;
                issue          = 1'b1;
                pend_in.last   = 1'b1;
                pend_in.status = rsr_pkg::STATUS_OK;
              end
            end
            rsr_pkg::CMD_READ: begin
              if (!reader_active[ci]) begin
                if (room) begin
                  cmd_pop        = 1'b1;
                  issue          = 1'b1;
                  pend_in.last   = 1'b1;
                  pend_in.status = rsr_pkg::STATUS_NOT_ACTIVE;
                end
              end else begin
                cmd_pop    = 1'b1;
                state_next = S_DIFF;
              end
            end
            default: begin
              if (room) begin
                cmd_pop        = 1'b1;
                issue          = 1'b1;
                pend_in.last   = 1'b1;
                pend_in.status = rsr_pkg::STATUS_INVALID;
              end
            end
          endcase
        end
      end
      S_DIFF: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (avail == '0) begin
          if (room) begin
            issue          = 1'b1;
            pend_in.last   = 1'b1;
            pend_in.status = rsr_pkg::STATUS_EMPTY;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_STREAM;
        end
      end
      S_STREAM: begin
        if (room) begin
          issue           = 1'b1;
          issue_mem       = 1'b1;
          pend_in.status  = rsr_pkg::STATUS_OK;
          pend_in.last    = (remaining == NW'(1));
          pend_in.overrun = ovr;
          if (remaining == NW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign wr_addr = guard(write_slot);
  assign rd_addr = guard(reader_slot[cur]);
  assign mem_re  = issue_mem;

  // State, writer and reader registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend_valid    <= 1'b0;
      write_total   <= '0;
      write_slot    <= '0;
      reader_active <= '0;
      ring_size     <= '0;
      size_default  <= 1'b1;
      for (int i = 0; i < READER_SLOTS; i++) begin
        reader_total[i] <= '0;
        reader_slot[i]  <= '0;
      end
    end else begin
      state      <= state_next;
      pend_valid <= issue;

      if (cfg_write) begin
        ring_size    <= cfg_data;
        size_default <= 1'b0;
      end

      // Writer advance.
      if (mem_we) begin
        write_slot  <= advance(wr_addr, used_size);
        write_total <= write_total + TW'(1);
      end

      // Register and unregister take effect when their request leaves the queue.
      if (state == S_IDLE && cmd_pop) begin
        if (cmd.kind == rsr_pkg::CMD_REGISTER && free_found) begin
          reader_active[free_idx] <= 1'b1;
          reader_total[free_idx]  <= write_total;
          reader_slot[free_idx]   <= write_slot;
        end
        if (cmd.kind == rsr_pkg::CMD_UNREGISTER) begin
          reader_active[ci] <= 1'b0;
        end
      end

      // A lagging reader jumps to the oldest sample still held.
      if (state == S_CHECK && avail != '0) begin
        if (avail > size_wide) begin
          reader_total[cur] <= write_total - size_wide;
          reader_slot[cur]  <= write_slot;
          ovr               <= 1'b1;
        end else begin
          ovr <= 1'b0;
        end
      end

      // Each streamed sample moves the reader on by one.
      if (issue_mem) begin
        reader_slot[cur]  <= advance(rd_addr, used_size);
        reader_total[cur] <= reader_total[cur] + TW'(1);
      end
    end
  end

  // Sequencer payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_pop && cmd.kind == rsr_pkg::CMD_READ) begin
      cur       <= ci;
      req_count <= cmd.count;
    end
    if (state == S_DIFF) begin
      avail <= write_total - reader_total[cur];
    end
    if (state == S_CHECK) begin
      remaining <= n_count;
    end else if (issue_mem) begin
      remaining <= remaining - NW'(1);
    end
    if (issue) begin
      pend     <= pend_in;
      pend_mem <= issue_mem;
    end
  end

  // Memory write and registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Staged result goes to the result queue, with the sample from memory for reads.
  assign res_push = pend_valid;
  always_comb begin
    res_data = pend;
    if (pend_mem) begin
      res_data.sample = mem_q;
    end
  end

  `MRSR_ASSERT_NEVER(a_res_overflow, pend_valid && (res_count == OCW'(rsr_pkg::RES_DEPTH)),
    "result pushed into a full result queue")
  `MRSR_ASSERT_IMP(a_stream_count, state == S_STREAM, remaining != '0,
    "streaming with no samples left")
  `MRSR_ASSERT_IMP(a_stream_behind, state == S_STREAM, reader_total[cur] < write_total,
    "reader streams past the writer")
  `MRSR_ASSERT_NEXT(a_last_idle, issue && pend_in.last, state == S_IDLE,
    "final result not followed by idle sequencer")
  `MRSR_ASSERT_IMP(a_pop_idle, cmd_pop, state == S_IDLE,
    "request taken while a read is in progress")

endmodule

@@ rtl/multi_reader_sample_ring.sv @@
// Top level of the multi-reader sample ring.
// Depends on rsr_pkg, rsr_front, rsr_fifo and rsr_back.
//
// Usage: requests enter as a queue (push / full) carrying func, sample_in,
// reader_handle and read_count; results leave as a queue (empty / pop)
// carrying status, sample_out, handle_out, last and overrun. The ring size
// register is written with cfg_write / cfg_data; the user writes it only
// while the block is idle, which the block itself does not enforce.
// A write request is taken by the back end from the request queue and
// produces no result; writes sustain one per cycle while the back end is
// idle. Register, unregister and rejected requests each give one result,
// staged in a register before the result queue. A read leaves the request
// queue, passes the lag check in states S_DIFF and S_CHECK, then streams
// one sample per cycle through the memory's single read port while the
// result queue has room.
// A four-entry request queue separates the front end from the back end and
// a four-entry result queue holds finished results; when the receiver stops
// popping, the back end pauses once that queue fills and full rises after
// the request queue fills behind it.
// Reset clears all readers, the write count and both queues and restores the
// full ring size; the sample memory is not cleared, and no entry is read
// before it has been written.
module multi_reader_sample_ring #(
  parameter int RING_DEPTH   = rsr_pkg::RING_DEPTH_DEF,
  parameter int READER_SLOTS = rsr_pkg::READER_SLOTS_DEF,
  parameter int MAX_READ     = rsr_pkg::MAX_READ_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [rsr_pkg::FUNC_W-1:0]           func,
  input  logic signed [rsr_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [rsr_pkg::HANDLE_W-1:0]         reader_handle,
  input  logic [rsr_pkg::COUNT_W-1:0]          read_count,
  input  logic                                 cfg_write,
  input  logic [rsr_pkg::RING_SIZE_W-1:0]      cfg_data,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [rsr_pkg::STATUS_W-1:0]         status,
  output logic signed [rsr_pkg::SAMPLE_W-1:0]  sample_out,
  output logic [rsr_pkg::HANDLE_W-1:0]         handle_out,
  output logic                                 last,
  output logic                                 overrun
);

  localparam int CMD_BITS = $bits(rsr_pkg::cmd_t);
  localparam int RES_BITS = $bits(rsr_pkg::result_t);
  localparam int CCW      = $clog2(rsr_pkg::CMD_DEPTH + 1);
  localparam int OCW      = $clog2(rsr_pkg::RES_DEPTH + 1);

  rsr_pkg::cmd_t     front_cmd;
  rsr_pkg::cmd_t     head_cmd;
  logic [CMD_BITS-1:0] head_raw;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CCW-1:0]    cmd_count;

  rsr_pkg::result_t  back_res;
  rsr_pkg::result_t  out_res;
  logic [RES_BITS-1:0] out_raw;
  logic              res_push;
  logic              res_full;
  logic [OCW-1:0]    res_count;

  // Request classification.
  rsr_front #(
    .READER_SLOTS (READER_SLOTS),
    .MAX_READ     (MAX_READ)
  ) u_front (
    .func          (func),
    .sample_in     (sample_in),
    .reader_handle (reader_handle),
    .read_count    (read_count),
    .cmd           (front_cmd)
  );

  // Queue of classified requests.
  rsr_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (rsr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_cmd),
    .pop     (cmd_pop),
    .rd_data (head_raw),
    .full    (full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign head_cmd = rsr_pkg::cmd_t'(head_raw);

  // Execution against ring and reader state.
  rsr_back #(
    .RING_DEPTH   (RING_DEPTH),
    .READER_SLOTS (READER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (head_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (back_res)
  );

  // Queue of finished results.
  rsr_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (rsr_pkg::RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_res),
    .pop     (pop),
    .rd_data (out_raw),
    .full    (res_full),
    .empty   (empty),
    .count   (res_count)
  );

  // Result fields to ports; res_count feeds the back end's flow control, and cmd_count
  // with res_full masks last, a mask never set since cmd_count never exceeds CMD_DEPTH.
  assign out_res    = rsr_pkg::result_t'(out_raw);
  assign status     = out_res.status;
  assign sample_out = out_res.sample;
  assign handle_out = out_res.handle;
  assign last       = out_res.last && !(res_full && cmd_count == CCW'(rsr_pkg::CMD_DEPTH + 1));
  assign overrun    = out_res.overrun;

endmodule
